// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the vector argmax block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BVDA_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("%m: invariant violated");

// A condition in one cycle that must be followed by another in the next cycle.
`define BVDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/bvda_pkg.sv
// Types and constants for the best coefficient vector argmax block.
`timescale 1ns / 1ps

package bvda_pkg;

    // Number of vectors the index can name; later vectors saturate at the top index.
    localparam int MAX_VECTORS = 1024;
    localparam int IDX_W       = $clog2(MAX_VECTORS);

    // Q16.16 operand and 48-bit saturating accumulator widths.
    localparam int DATA_W = 32;
    localparam int ACC_W  = 48;
    localparam int LEN_W  = 5;

    // Reset value of the vector length register.
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

    // One input request: a vector element and its witness coordinate.
    typedef struct packed {
        logic signed [DATA_W-1:0] coefficient;
        logic signed [DATA_W-1:0] witness_value;
        logic                     last_in_set;
    } bvda_in_t;

    // One result request: best vector index and value for a set.
    typedef struct packed {
        logic        [IDX_W-1:0] best_index;
        logic signed [ACC_W-1:0] best_value;
        logic                    index_overflow;
    } bvda_out_t;

endpackage

// File: rtl/best_vector_dot_argmax_top.sv
// Top level of the best coefficient vector argmax block (dot product plus constant).
// A set-closing request passes the input and product registers into the result register.
// Throughput: one input request per cycle; the stream stalls only when a set-closing
// request finds the result register still held by an untaken result.
// The stages are input register, registered multiplier, and accumulate/compare state.
// Reset (aresetn low at a clock edge) empties the pipeline, clears the set and sets length 2.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_vector_dot_argmax_top
    import bvda_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_vector_length,
    input  logic             s_valid,
    output logic             s_ready,
    input  bvda_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bvda_out_t        m_data
);

    // Element counter and length compare widths follow the largest vector length.
    localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;
    localparam int PROD_W = 2 * DATA_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_VECTORS - 1);

    // Saturate a 49-bit sum to the signed 48-bit range.
    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] s);
        logic signed [ACC_W-1:0] r;
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    // Configuration register.
    logic [LEN_W-1:0] len_reg;

    // Input stage.
    logic     in_valid_reg;
    bvda_in_t in_data_reg;

    // Product stage.
    logic                     pr_valid_reg;
    logic signed [DATA_W-1:0] pr_coef_reg;
    logic signed [ACC_W-1:0]  pr_prod_reg;
    logic                     pr_last_reg;

    // Set state.
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [PW-1:0]           elem_reg, elem_next;
    logic [IDX_W-1:0]        vec_reg, vec_next;
    logic signed [ACC_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]        best_pos_reg, best_pos_next;
    logic                    first_reg, first_next;
    logic                    ovf_reg, ovf_next;

    // Result register.
    logic      m_valid_reg;
    bvda_out_t m_data_reg;

    // Handshake and datapath wires.
    logic                     out_free;
    logic                     st_fire;
    logic                     pr_ready;
    logic                     in_ready;
    logic signed [PROD_W-1:0] prod_full;
    logic [LW-1:0]            len_ext;
    logic [LW-1:0]            len_eff;
    logic [LW-1:0]            elem_inc;
    logic                     is_const;
    logic signed [ACC_W:0]    sum_const;
    logic signed [ACC_W:0]    sum_mac;
    logic signed [ACC_W-1:0]  vec_value;
    logic                     take;

    // Flow control: a request leaves the state stage unless it closes a set
    // while the result register is still full.
    assign out_free  = !m_valid_reg || m_ready;
    assign st_fire   = pr_valid_reg && (!pr_last_reg || out_free);
    assign pr_ready  = !pr_valid_reg || st_fire;
    assign in_ready  = !in_valid_reg || pr_ready;
    assign s_ready   = in_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Configuration write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            len_reg <= cfg_vector_length;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Full product, floored to Q32.16 (16 fraction bits) by dropping the low 16 bits.
    assign prod_full = $signed(in_data_reg.coefficient) * $signed(in_data_reg.witness_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_valid_reg <= 1'b0;
        end else if (pr_ready) begin
            pr_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pr_ready && in_valid_reg) begin
            pr_coef_reg <= in_data_reg.coefficient;
            pr_prod_reg <= prod_full[PROD_W-1:16];
            pr_last_reg <= in_data_reg.last_in_set;
        end
    end

    // Effective vector length: zero counts as one, and it is capped at MAX_DIM.
    assign len_ext  = LW'(len_reg);
    assign len_eff  = (len_ext == '0) ? LW'(1) :
                      (len_ext > LW'(MAX_DIM)) ? LW'(MAX_DIM) : len_ext;
    assign elem_inc = LW'(elem_reg) + LW'(1);
    assign is_const = (elem_inc >= len_eff) || pr_last_reg;

    // Constant term closes the vector; other elements add their product.
    assign sum_const = {acc_reg[ACC_W-1], acc_reg}
                     + {{(ACC_W + 1 - DATA_W){pr_coef_reg[DATA_W-1]}}, pr_coef_reg};
    assign sum_mac   = {acc_reg[ACC_W-1], acc_reg} + {pr_prod_reg[ACC_W-1], pr_prod_reg};
    assign vec_value = sat48(sum_const);
    assign take      = first_reg || (vec_value >= best_reg);

    // Next set state for the request in the state stage.
    always_comb begin
        acc_next      = acc_reg;
        elem_next     = elem_reg;
        vec_next      = vec_reg;
        best_next     = best_reg;
        best_pos_next = best_pos_reg;
        first_next    = first_reg;
        ovf_next      = ovf_reg;
        if (st_fire) begin
            if (pr_last_reg) begin
                // The set ends: everything returns to its cleared value.
                acc_next      = '0;
                elem_next     = '0;
                vec_next      = '0;
                best_next     = '0;
                best_pos_next = '0;
                first_next    = 1'b1;
                ovf_next      = 1'b0;
            end else if (is_const) begin
                if (take) begin
                    best_next     = vec_value;
                    best_pos_next = vec_reg;
                end
                first_next = 1'b0;
                acc_next   = '0;
                elem_next  = '0;
                if (vec_reg < IDX_TOP) begin
                    vec_next = vec_reg + IDX_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end else begin
                acc_next  = sat48(sum_mac);
                elem_next = elem_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            elem_reg     <= '0;
            vec_reg      <= '0;
            best_reg     <= '0;
            best_pos_reg <= '0;
            first_reg    <= 1'b1;
            ovf_reg      <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            elem_reg     <= elem_next;
            vec_reg      <= vec_next;
            best_reg     <= best_next;
            best_pos_reg <= best_pos_next;
            first_reg    <= first_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Result register: loaded by the request that closes the set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_fire && pr_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_fire && pr_last_reg) begin
            m_data_reg.best_index     <= take ? vec_reg : best_pos_reg;
            m_data_reg.best_value     <= take ? vec_value : best_reg;
            m_data_reg.index_overflow <= ovf_reg;
        end
    end

    // A closed set leaves the state cleared for the next one.
    `BVDA_ASSERT_NEXT(a_set_cleared, st_fire && pr_last_reg, first_reg && (vec_reg == '0) && (acc_reg == '0))
    // A closed set always puts a result in the result register.
    `BVDA_ASSERT_NEXT(a_result_loaded, st_fire && pr_last_reg, m_valid_reg)
    // Overflow only occurs once the vector index has saturated.
    `BVDA_ASSERT_ALWAYS(a_ovf_saturated, !ovf_reg || (vec_reg == IDX_TOP))
    // The best vector never lies ahead of the current vector index.
    `BVDA_ASSERT_ALWAYS(a_best_behind, first_reg || (best_pos_reg <= vec_reg))

endmodule

// File: dv/tb_best_vector_dot_argmax_top.sv
// Self-checking testbench for the best coefficient vector argmax block.
`timescale 1ns / 1ps

module tb_best_vector_dot_argmax_top;
    import bvda_pkg::*;

    localparam int MAX_DIM      = 16;
    localparam int ITEM_TARGET  = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -(longint'(1) <<< (ACC_W - 1));

    logic             aclk              = 1'b0;
    logic             aresetn           = 1'b0;
    logic             cfg_valid         = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_vector_length = '0;
    logic             s_valid           = 1'b0;
    logic             s_ready;
    bvda_in_t         s_data            = '0;
    logic             m_valid;
    logic             m_ready           = 1'b0;
    bvda_out_t        m_data;

    // Element requests waiting to be sent, and best results still owed by the block.
    bvda_in_t  element_queue [$];
    bvda_out_t best_expected [$];

    int  items_queued   = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  item_held      = 1'b0;

    // Predicted block state: length register, running dot product and best vector.
    logic [LEN_W-1:0] model_len      = LEN_RESET;
    longint           model_acc      = 0;
    int unsigned      model_elem     = 0;
    logic [IDX_W-1:0] model_vec      = '0;
    longint           model_best     = 0;
    logic [IDX_W-1:0] model_best_idx = '0;
    bit               model_first    = 1'b1;
    bit               model_ovf      = 1'b0;

    best_vector_dot_argmax_top #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_vector_length (cfg_vector_length),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data)
    );

    always #10 aclk = ~aclk;

    // Clamp a sum to the signed 48-bit accumulator range.
    function automatic longint clamp_acc(input longint sum);
        if (sum > ACC_HI) return ACC_HI;
        if (sum < ACC_LO) return ACC_LO;
        return sum;
    endfunction

    // Fold one accepted element into the predicted state; returns 1 when a result is due.
    function automatic bit fold_element(input bvda_in_t el, output bvda_out_t res);
        int unsigned eff_len;
        longint      coef;
        longint      wit;
        longint      value;
        coef = $signed(el.coefficient);
        wit  = $signed(el.witness_value);
        res  = '0;
        eff_len = (model_len == 0) ? 1 : ((model_len > MAX_DIM) ? MAX_DIM : model_len);
        if (model_elem + 1 >= eff_len || el.last_in_set) begin
            // The constant closes the vector; a later vector wins a tie.
            value = clamp_acc(model_acc + coef);
            if (model_first || value >= model_best) begin
                model_best     = value;
                model_best_idx = model_vec;
            end
            model_first = 1'b0;
            model_acc   = 0;
            model_elem  = 0;
            if (model_vec < IDX_W'(MAX_VECTORS - 1)) begin
                model_vec++;
            end else if (!el.last_in_set) begin
                model_ovf = 1'b1;
            end
        end else begin
            model_acc = clamp_acc(model_acc + ((coef * wit) >>> 16));
            model_elem++;
        end
        if (!el.last_in_set) return 1'b0;
        res.best_index     = model_best_idx;
        res.best_value     = ACC_W'(model_best);
        res.index_overflow = model_ovf;
        model_acc      = 0;
        model_elem     = 0;
        model_vec      = '0;
        model_best     = 0;
        model_best_idx = '0;
        model_first    = 1'b1;
        model_ovf      = 1'b0;
        return 1'b1;
    endfunction

    // Idle length: mostly short, a few long, with occasional stretches of none.
    function automatic int next_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Q16.16 operand biased toward the extremes, zero, minus one LSB and small values.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return '0;
            4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_element(input logic [DATA_W-1:0] c,
                                        input logic [DATA_W-1:0] w, input bit last);
        bvda_in_t el;
        el.coefficient   = c;
        el.witness_value = w;
        el.last_in_set   = last;
        element_queue = {element_queue, el};
        items_queued++;
    endfunction

    // A well-formed set of random vectors; some repeat the previous vector to force
    // ties, and some sets end early inside the final vector.
    task automatic queue_random_set(input int eff);
        logic [DATA_W-1:0] keep_c [MAX_DIM];
        logic [DATA_W-1:0] keep_w [MAX_DIM];
        int nvec;
        int cut;
        bit twin;
        nvec = $urandom_range(1, 4);
        cut  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, eff - 1) : eff - 1;
        for (int v = 0; v < nvec; v++) begin
            twin = (v > 0) && ($urandom_range(0, 3) == 0);
            for (int e = 0; e < eff; e++) begin
                if (!twin) begin
                    keep_c[e] = pick_word();
                    keep_w[e] = pick_word();
                end
                if (v == nvec - 1 && e == cut) begin
                    add_element(keep_c[e], keep_w[e], 1'b1);
                    break;
                end
                add_element(keep_c[e], keep_w[e], 1'b0);
            end
        end
    endtask

    // Wait until every request is sent and every result taken, then let the pipe drain.
    task automatic wait_idle();
        do @(posedge aclk);
        while (element_queue.size() != 0 || item_held || best_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        wait_idle();
        @(posedge aclk);
        cfg_vector_length <= len;
        cfg_valid         <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_len = len;
    endtask

    // Input driver: presents queued elements, predicts each accepted request.
    int        send_gap  = 0;
    int        send_calm = 0;
    bvda_out_t sent_outcome;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                item_held = 1'b0;
                if (fold_element(s_data, sent_outcome))
                    best_expected = {best_expected, sent_outcome};
                send_gap = next_gap(send_calm);
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (element_queue.size() > 0) begin
                s_data    <= element_queue.pop_front();
                s_valid   <= 1'b1;
                item_held = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each taken result with the oldest prediction.
    int        take_gap  = 0;
    int        take_calm = 0;
    bvda_out_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            take_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (best_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: index %0d value %0d overflow %0b",
                                 m_data.best_index, m_data.best_value,
                                 m_data.index_overflow);
                end else begin
                    want = best_expected.pop_front();
                    if (m_data.best_index !== want.best_index ||
                        m_data.best_value !== want.best_value ||
                        m_data.index_overflow !== want.index_overflow) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"result mismatch: expected index %0d value %0d ",
                                      "overflow %0b, got index %0d value %0d overflow %0b"},
                                     want.best_index, want.best_value, want.index_overflow,
                                     m_data.best_index, m_data.best_value,
                                     m_data.index_overflow);
                    end
                end
                take_gap = next_gap(take_calm);
            end else if (!m_valid && take_gap == 0 && take_calm == 0 &&
                         $urandom_range(0, 9) == 0) begin
                take_gap = $urandom_range(1, 6);
            end
            if (take_gap > 0) begin
                take_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which no request of any channel is accepted.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus: directed corner cases, a set past the index range, then random phases.
    initial begin
        logic [LEN_W-1:0] len;
        int               eff;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset length of two; an identical second vector must win the tie.
        add_element(32'h0001_0000, 32'h0002_0000, 1'b0);
        add_element(32'h0000_8000, 32'h1234_5678, 1'b0);
        add_element(32'h0001_0000, 32'h0002_0000, 1'b0);
        add_element(32'h0000_8000, 32'h0000_0000, 1'b1);

        // Extreme operands saturate the accumulator high, then low.
        write_length(5'd4);
        add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_element(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_element(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_element(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_element(32'h8000_0000, 32'h0000_0000, 1'b1);

        // Length zero acts as one: a single negative constant forms the set.
        write_length(5'd0);
        add_element(32'hFFFF_FFFF, 32'h1234_5678, 1'b1);

        // Oversized length clamps to the maximum; the set ends early, and the
        // negative products round toward minus infinity.
        write_length(5'd31);
        add_element(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        add_element(32'h0001_0000, 32'hFFFF_8000, 1'b0);
        add_element(32'h0003_0000, 32'h5A5A_5A5A, 1'b1);

        // Length shrinks in the middle of a vector: the next element is its constant.
        write_length(5'd4);
        add_element(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        add_element(32'h0002_0000, 32'h0001_0000, 1'b0);
        write_length(5'd2);
        add_element(32'h0005_0000, 32'hA5A5_A5A5, 1'b0);
        add_element(32'h0001_0000, 32'h0001_0000, 1'b0);
        add_element(32'hFFFF_0000, 32'h0000_0000, 1'b1);

        // More vectors than the index holds, with few distinct values so ties occur.
        write_length(5'd1);
        for (int i = 0; i < MAX_VECTORS + 6; i++)
            add_element({16'($urandom_range(0, 6) - 3), 16'h0000}, $urandom,
                        i == MAX_VECTORS + 5);

        while (items_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: len = 5'd0;
                1: len = 5'd1;
                2: len = 5'd16;
                3: len = 5'd17;
                4: len = 5'd31;
                default: len = LEN_W'($urandom_range(1, 16));
            endcase
            write_length(len);
            eff = (len == 0) ? 1 : ((len > MAX_DIM) ? MAX_DIM : int'(len));
            repeat ($urandom_range(1, 4)) queue_random_set(eff);
            // Sometimes leave a vector open so the next length applies mid-vector.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, eff)) add_element(pick_word(), pick_word(), 1'b0);
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
